>>> sv/rusi_pkg.sv
package rusi_pkg;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned TBits       = WordBits - 1;
  localparam int unsigned MdBits      = FracBits + 1;
  localparam int unsigned ProdBits    = 2 * WordBits;
  localparam int unsigned AW          = ProdBits;
  localparam int unsigned BW          = ProdBits + 1;
  localparam int unsigned HalfBits    = ProdBits / 2;
  localparam int unsigned SqBits      = 2 * ProdBits;
  localparam int unsigned DiscBits    = AW + 2 * FracBits;
  localparam int unsigned RadBits     = DiscBits + 2 * FracBits;
  localparam int unsigned RootBits    = RadBits / 2;
  localparam int unsigned RemBits     = RootBits + 2;
  localparam int unsigned TrBits      = RemBits + 2;
  localparam int unsigned NumBits     = BW + FracBits + 2;
  localparam int unsigned DivBits     = AW + TBits;
  localparam int unsigned SumBits     = ProdBits - FracBits + 1;
  localparam int unsigned FrontStages = 5;
  localparam int unsigned SelStages   = 2;
  localparam int unsigned PointStages = 2;
  localparam int unsigned Latency     = FrontStages + RootBits + SelStages + TBits + PointStages;

  typedef struct packed {
    logic [WordBits-1:0] ox;
    logic [WordBits-1:0] oy;
    logic [WordBits-1:0] oz;
    logic [WordBits-1:0] dx;
    logic [WordBits-1:0] dy;
    logic [WordBits-1:0] dz;
    logic                have;
    logic [TBits-1:0]    best;
  } ray_t;

  typedef struct packed {
    logic          miss;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
  } quad_t;

endpackage

>>> sv/rusi_front.sv
module rusi_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rusi_pkg::ray_t                ray_i,
  output logic                          valid_o,
  output rusi_pkg::ray_t                ray_o,
  output rusi_pkg::quad_t               quad_o,
  output logic [rusi_pkg::DiscBits-1:0] disc_o
);
  import rusi_pkg::*;

  logic [FrontStages-1:0] v_q;
  ray_t ray_q [FrontStages];

  logic signed [WordBits-1:0] o_w [3];
  logic signed [WordBits-1:0] d_w [3];

  logic [ProdBits-1:0]        sq1_d [3];
  logic [ProdBits-1:0]        sq1_q [3];
  logic signed [ProdBits-1:0] od1_d [3];
  logic signed [ProdBits-1:0] od1_q [3];
  logic signed [ProdBits-1:0] cp1_d [6];
  logic signed [ProdBits-1:0] cp1_q [6];

  logic [AW-1:0]       a2_d, a2_q, a3_q, a4_q;
  logic [BW-1:0]       b2_d, b2_q, b3_q, b4_q;
  logic [BW-1:0]       cd2   [3];
  logic [ProdBits-1:0] mag2_d [3];
  logic [ProdBits-1:0] mag2_q [3];

  logic [ProdBits-1:0] hh3_q [3];
  logic [ProdBits-1:0] hl3_q [3];
  logic [ProdBits-1:0] ll3_q [3];

  logic [SqBits-1:0] sq4_d [3];
  logic [SqBits-1:0] sq4_q [3];

  logic [SqBits-1:0] xsum5;
  logic [SqBits:0]   diff5;
  quad_t             quad5_d, quad5_q;
  logic [DiscBits-1:0] disc5_q;

  assign o_w[0] = ray_i.ox;
  assign o_w[1] = ray_i.oy;
  assign o_w[2] = ray_i.oz;
  assign d_w[0] = ray_i.dx;
  assign d_w[1] = ray_i.dy;
  assign d_w[2] = ray_i.dz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq1_d[i] = d_w[i] * d_w[i];
      od1_d[i] = o_w[i] * d_w[i];
    end
    cp1_d[0] = o_w[1] * d_w[2];
    cp1_d[1] = o_w[2] * d_w[1];
    cp1_d[2] = o_w[2] * d_w[0];
    cp1_d[3] = o_w[0] * d_w[2];
    cp1_d[4] = o_w[0] * d_w[1];
    cp1_d[5] = o_w[1] * d_w[0];
  end

  always_comb begin
    a2_d = sq1_q[0] + sq1_q[1] + sq1_q[2];
    b2_d = {od1_q[0][ProdBits-1], od1_q[0]} + {od1_q[1][ProdBits-1], od1_q[1]}
         + {od1_q[2][ProdBits-1], od1_q[2]};
    for (int i = 0; i < 3; i++) begin
      cd2[i] = {cp1_q[2*i][ProdBits-1], cp1_q[2*i]}
             - {cp1_q[2*i+1][ProdBits-1], cp1_q[2*i+1]};
      mag2_d[i] = cd2[i][BW-1] ? ProdBits'(-cd2[i]) : cd2[i][ProdBits-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_d[i] = {hh3_q[i], ll3_q[i]} + (SqBits'(hl3_q[i]) << (HalfBits + 1));
    end
  end

  always_comb begin
    xsum5 = sq4_q[0] + sq4_q[1] + sq4_q[2];
    diff5 = (SqBits+1)'({a4_q, {(2*FracBits){1'b0}}}) - {1'b0, xsum5};
    quad5_d.miss = diff5[SqBits] || (a4_q == '0);
    quad5_d.a    = a4_q;
    quad5_d.b    = b4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q[0] <= ray_i;
    for (int k = 1; k < FrontStages; k++) begin
      ray_q[k] <= ray_q[k-1];
    end
    sq1_q  <= sq1_d;
    od1_q  <= od1_d;
    cp1_q  <= cp1_d;
    a2_q   <= a2_d;
    b2_q   <= b2_d;
    mag2_q <= mag2_d;
    a3_q   <= a2_q;
    b3_q   <= b2_q;
    for (int i = 0; i < 3; i++) begin
      hh3_q[i] <= mag2_q[i][ProdBits-1:HalfBits] * mag2_q[i][ProdBits-1:HalfBits];
      hl3_q[i] <= mag2_q[i][ProdBits-1:HalfBits] * mag2_q[i][HalfBits-1:0];
      ll3_q[i] <= mag2_q[i][HalfBits-1:0] * mag2_q[i][HalfBits-1:0];
    end
    a4_q    <= a3_q;
    b4_q    <= b3_q;
    sq4_q   <= sq4_d;
    quad5_q <= quad5_d;
    disc5_q <= diff5[DiscBits-1:0];
  end

  assign valid_o = v_q[FrontStages-1];
  assign ray_o   = ray_q[FrontStages-1];
  assign quad_o  = quad5_q;
  assign disc_o  = disc5_q;

endmodule

>>> sv/rusi_sqrt.sv
module rusi_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rusi_pkg::ray_t                ray_i,
  input  rusi_pkg::quad_t               quad_i,
  input  logic [rusi_pkg::DiscBits-1:0] disc_i,
  output logic                          valid_o,
  output rusi_pkg::ray_t                ray_o,
  output rusi_pkg::quad_t               quad_o,
  output logic [rusi_pkg::RootBits-1:0] root_o
);
  import rusi_pkg::*;

  logic [RootBits-1:0] v_q;
  ray_t                ray_q  [RootBits];
  quad_t               quad_q [RootBits];
  logic [RadBits-1:0]  rad_q  [RootBits];
  logic [RemBits-1:0]  rem_q  [RootBits];
  logic [RootBits-1:0] root_q [RootBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[RootBits-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < RootBits; s++) begin : g_stage
    ray_t                ray_p;
    quad_t               quad_p;
    logic [RadBits-1:0]  rad_p;
    logic [RemBits-1:0]  rem_p;
    logic [RootBits-1:0] root_p;
    logic [TrBits-1:0]   rin;
    logic [TrBits-1:0]   trial;
    logic [TrBits-1:0]   diff;
    logic                ge;

    if (s == 0) begin : g_head
      assign ray_p  = ray_i;
      assign quad_p = quad_i;
      assign rad_p  = {disc_i, {(2*FracBits){1'b0}}};
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_tail
      assign ray_p  = ray_q[s-1];
      assign quad_p = quad_q[s-1];
      assign rad_p  = rad_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
    end

    assign rin   = {rem_p, rad_p[RadBits-1 -: 2]};
    assign trial = {{(TrBits-RootBits-2){1'b0}}, root_p, 2'b01};
    assign ge    = rin >= trial;
    assign diff  = rin - trial;

    always_ff @(posedge clk_i) begin
      ray_q[s]  <= ray_p;
      quad_q[s] <= quad_p;
      rad_q[s]  <= rad_p << 2;
      rem_q[s]  <= ge ? diff[RemBits-1:0] : rin[RemBits-1:0];
      root_q[s] <= {root_p[RootBits-2:0], ge};
    end
  end

  assign valid_o = v_q[RootBits-1];
  assign ray_o   = ray_q[RootBits-1];
  assign quad_o  = quad_q[RootBits-1];
  assign root_o  = root_q[RootBits-1];

endmodule

>>> sv/rusi_div.sv
module rusi_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rusi_pkg::ray_t                ray_i,
  input  rusi_pkg::quad_t               quad_i,
  input  logic [rusi_pkg::RootBits-1:0] root_i,
  output logic                          valid_o,
  output rusi_pkg::ray_t                ray_o,
  output logic                          ok_o,
  output logic [rusi_pkg::TBits-1:0]    q_o
);
  import rusi_pkg::*;

  logic [SelStages-1:0] vs_q;
  ray_t                 rays_q [SelStages];

  logic [NumBits-1:0] bs, rx, n1_d, n2_d;
  logic [NumBits-1:0] n1_q, n2_q;
  logic [AW-1:0]      aa_q, ab_q;
  logic               missa_q;

  logic [NumBits-1:0] ax, num;
  logic [DivBits-1:0] numx, lim;
  logic               p1, p2, n2neg, ok_d;
  logic               okb_q;
  logic [DivBits-1:0] numb_q;

  logic [TBits-1:0]   v_q;
  ray_t               ray_q [TBits];
  logic               ok_q  [TBits];
  logic [AW-1:0]      a_q   [TBits];
  logic [AW-1:0]      rem_q [TBits];
  logic [TBits-1:0]   low_q [TBits];
  logic [TBits-1:0]   quo_q [TBits];

  assign bs   = {{(NumBits-BW-FracBits){quad_i.b[BW-1]}}, quad_i.b, {FracBits{1'b0}}};
  assign rx   = {{(NumBits-RootBits){1'b0}}, root_i};
  assign n1_d = rx - bs;
  assign n2_d = '0 - bs - rx;

  assign ax    = {{(NumBits-AW){1'b0}}, aa_q};
  assign n2neg = n2_q[NumBits-1];
  assign p1    = !n1_q[NumBits-1] && (n1_q >= ax);
  assign p2    = !n2neg && (n2_q >= ax);
  assign num   = n2neg ? n1_q : n2_q;
  assign numx  = {{(DivBits-NumBits){1'b0}}, num};
  assign lim   = {aa_q, {TBits{1'b0}}};
  assign ok_d  = !missa_q && p1 && (n2neg || p2) && (numx < lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
      v_q  <= '0;
    end else begin
      vs_q <= {vs_q[SelStages-2:0], valid_i};
      v_q  <= {v_q[TBits-2:0], vs_q[SelStages-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    rays_q[0] <= ray_i;
    for (int k = 1; k < SelStages; k++) begin
      rays_q[k] <= rays_q[k-1];
    end
    n1_q    <= n1_d;
    n2_q    <= n2_d;
    aa_q    <= quad_i.a;
    missa_q <= quad_i.miss;
    ab_q    <= aa_q;
    okb_q   <= ok_d;
    numb_q  <= numx;
  end

  for (genvar s = 0; s < TBits; s++) begin : g_stage
    ray_t             ray_p;
    logic             ok_p;
    logic [AW-1:0]    a_p;
    logic [AW-1:0]    rem_p;
    logic [TBits-1:0] low_p;
    logic [TBits-1:0] quo_p;
    logic [AW:0]      rin;
    logic [AW:0]      diff;
    logic             ge;

    if (s == 0) begin : g_head
      assign ray_p = rays_q[SelStages-1];
      assign ok_p  = okb_q;
      assign a_p   = ab_q;
      assign rem_p = numb_q[DivBits-1 -: AW];
      assign low_p = numb_q[TBits-1:0];
      assign quo_p = '0;
    end else begin : g_tail
      assign ray_p = ray_q[s-1];
      assign ok_p  = ok_q[s-1];
      assign a_p   = a_q[s-1];
      assign rem_p = rem_q[s-1];
      assign low_p = low_q[s-1];
      assign quo_p = quo_q[s-1];
    end

    assign rin  = {rem_p, low_p[TBits-1]};
    assign ge   = rin >= {1'b0, a_p};
    assign diff = rin - {1'b0, a_p};

    always_ff @(posedge clk_i) begin
      ray_q[s] <= ray_p;
      ok_q[s]  <= ok_p;
      a_q[s]   <= a_p;
      rem_q[s] <= ge ? diff[AW-1:0] : rin[AW-1:0];
      low_q[s] <= low_p << 1;
      quo_q[s] <= {quo_p[TBits-2:0], ge};
    end
  end

  assign valid_o = v_q[TBits-1];
  assign ray_o   = ray_q[TBits-1];
  assign ok_o    = ok_q[TBits-1];
  assign q_o     = quo_q[TBits-1];

endmodule

>>> sv/rusi_point.sv
module rusi_point (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rusi_pkg::ray_t                ray_i,
  input  logic                          ok_i,
  input  logic [rusi_pkg::TBits-1:0]    q_i,
  input  logic [rusi_pkg::MdBits-1:0]   md_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [rusi_pkg::TBits-1:0]    hit_t_o,
  output logic [rusi_pkg::WordBits-1:0] point_o [3]
);
  import rusi_pkg::*;

  logic [PointStages-1:0] v_q;

  logic signed [WordBits-1:0] tq;
  logic signed [WordBits-1:0] d_w [3];
  logic                       hit1_d, hit1_q;
  logic [TBits-1:0]           t1_q;
  logic signed [ProdBits-1:0] prod1_q [3];
  logic [WordBits-1:0]        o1_q    [3];

  logic [SumBits-1:0]  sum2 [3];
  logic [WordBits-1:0] sat2 [3];
  logic                hit2_q;
  logic [TBits-1:0]    t2_q;
  logic [WordBits-1:0] p2_q [3];

  assign tq     = {1'b0, q_i};
  assign d_w[0] = ray_i.dx;
  assign d_w[1] = ray_i.dy;
  assign d_w[2] = ray_i.dz;
  assign hit1_d = ok_i && (q_i > {{(TBits-MdBits){1'b0}}, md_i})
                && (!ray_i.have || (q_i < ray_i.best));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum2[i] = {{(SumBits-WordBits){o1_q[i][WordBits-1]}}, o1_q[i]}
              + {prod1_q[i][ProdBits-1], prod1_q[i][ProdBits-1:FracBits]};
      if ((&sum2[i][SumBits-1:WordBits-1]) || !(|sum2[i][SumBits-1:WordBits-1])) begin
        sat2[i] = sum2[i][WordBits-1:0];
      end else if (sum2[i][SumBits-1]) begin
        sat2[i] = {1'b1, {(WordBits-1){1'b0}}};
      end else begin
        sat2[i] = {1'b0, {(WordBits-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PointStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    hit1_q <= hit1_d;
    t1_q   <= q_i;
    for (int i = 0; i < 3; i++) begin
      prod1_q[i] <= tq * d_w[i];
    end
    o1_q[0] <= ray_i.ox;
    o1_q[1] <= ray_i.oy;
    o1_q[2] <= ray_i.oz;
    hit2_q  <= hit1_q;
    t2_q    <= hit1_q ? t1_q : '0;
    for (int i = 0; i < 3; i++) begin
      p2_q[i] <= hit1_q ? sat2[i] : '0;
    end
  end

  assign done_o  = v_q[PointStages-1];
  assign hit_o   = hit2_q && v_q[PointStages-1];
  assign hit_t_o = t2_q;
  assign point_o = p2_q;

endmodule

>>> sv/ray_unit_sphere_intersect_core.sv
// Channel   Direction  Handshake                 Beat
// command   in         start_i, busy_o           ray origin, direction, prior hit
// result    out        done_o                    hit, hit_t, hit point
// config    in         min_distance_we_i         min_distance
//
// One beat is taken every cycle; busy_o stays low.
// Each result passes through the front stages, the 64-stage square-root
// pipeline, the select stages, the 31-stage divider pipeline and the point stages.
// Reset clears the valid bits of every stage and min_distance.
// The receiver cannot stall; results stream out in order, one per command.
module ray_unit_sphere_intersect_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rusi_pkg::WordBits-1:0] origin_x_i,
  input  logic [rusi_pkg::WordBits-1:0] origin_y_i,
  input  logic [rusi_pkg::WordBits-1:0] origin_z_i,
  input  logic [rusi_pkg::WordBits-1:0] dir_x_i,
  input  logic [rusi_pkg::WordBits-1:0] dir_y_i,
  input  logic [rusi_pkg::WordBits-1:0] dir_z_i,
  input  logic                          have_hit_i,
  input  logic [rusi_pkg::TBits-1:0]    best_t_i,
  input  logic                          min_distance_we_i,
  input  logic [rusi_pkg::MdBits-1:0]   min_distance_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [rusi_pkg::TBits-1:0]    hit_t_o,
  output logic [rusi_pkg::WordBits-1:0] point_x_o,
  output logic [rusi_pkg::WordBits-1:0] point_y_o,
  output logic [rusi_pkg::WordBits-1:0] point_z_o
);
  import rusi_pkg::*;

  logic [MdBits-1:0] min_distance_q;

  logic                in_valid;
  ray_t                ray_in;
  logic                fr_valid;
  ray_t                fr_ray;
  quad_t               fr_quad;
  logic [DiscBits-1:0] fr_disc;
  logic                sq_valid;
  ray_t                sq_ray;
  quad_t               sq_quad;
  logic [RootBits-1:0] sq_root;
  logic                dv_valid;
  ray_t                dv_ray;
  logic                dv_ok;
  logic [TBits-1:0]    dv_q;
  logic [WordBits-1:0] point [3];

  assign busy_o   = 1'b0;
  assign in_valid = start_i && !busy_o;
  assign ray_in   = '{ox: origin_x_i, oy: origin_y_i, oz: origin_z_i,
                      dx: dir_x_i, dy: dir_y_i, dz: dir_z_i,
                      have: have_hit_i, best: best_t_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_distance_q <= '0;
    end else if (min_distance_we_i) begin
      min_distance_q <= min_distance_i;
    end
  end

  rusi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ray_i   (ray_in),
    .valid_o (fr_valid),
    .ray_o   (fr_ray),
    .quad_o  (fr_quad),
    .disc_o  (fr_disc)
  );

  rusi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ray_i   (fr_ray),
    .quad_i  (fr_quad),
    .disc_i  (fr_disc),
    .valid_o (sq_valid),
    .ray_o   (sq_ray),
    .quad_o  (sq_quad),
    .root_o  (sq_root)
  );

  rusi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ray_i   (sq_ray),
    .quad_i  (sq_quad),
    .root_i  (sq_root),
    .valid_o (dv_valid),
    .ray_o   (dv_ray),
    .ok_o    (dv_ok),
    .q_o     (dv_q)
  );

  rusi_point u_point (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .ray_i   (dv_ray),
    .ok_i    (dv_ok),
    .q_i     (dv_q),
    .md_i    (min_distance_q),
    .done_o  (done_o),
    .hit_o   (hit_o),
    .hit_t_o (hit_t_o),
    .point_o (point)
  );

  assign point_x_o = point[0];
  assign point_y_o = point[1];
  assign point_z_o = point[2];

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> hit_t_o == '0 && point_x_o == '0 && point_y_o == '0
                         && point_z_o == '0)
    else $error("miss beat carries nonzero fields");

  a_hit_beyond_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> hit_t_o > {{(TBits-MdBits){1'b0}}, min_distance_q})
    else $error("hit distance not above min_distance");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("result beat missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result beat without command beat");

endmodule
